// ===== hw/rtl/imu_ca_pkg.sv =====
// Shared types, constants and tables for the complementary attitude block.
// Used by the divider, CORDIC lanes and the top level.
`timescale 1ns / 1ps
`default_nettype none
package imu_ca_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  // field and datapath widths
  localparam int RAW_W    = 16;
  localparam int ANG_W    = 32;
  localparam int OFS_W    = 24;
  localparam int SUM_W    = 32;
  localparam int CNT_W    = 16;
  localparam int DT_W     = 24;
  localparam int TAU_W    = 16;
  localparam int CFG_W    = 24;
  localparam int NUM_W    = 54;
  localparam int DEN_W    = 36;
  localparam int DELTA_W  = 36;
  localparam int STEP_W   = 5;
  localparam int MAX_STEPS = 24;

  // register indexes
  typedef enum logic [1:0] {
    REG_GYRO_RANGE    = 2'd0,
    REG_BLEND_TAU     = 2'd1,
    REG_SAMPLE_PERIOD = 2'd2,
    REG_CAL_POINTS    = 2'd3
  } reg_idx_t;

  localparam logic ACT_MEASURE   = 1'b0;
  localparam logic ACT_CALIBRATE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CAL_CHK, S_MUL, S_DIV_GO, S_WAIT, S_OFF_WR, S_BLD_MUL, S_BLD_SUM, S_OUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic div_go;
    logic cor_go;
  } ctl_t;

  // atan(2^-i) in degrees, Q.24
  function automatic logic signed [33:0] atan_lut(input logic [STEP_W-1:0] i);
    logic signed [33:0] v;
    unique case (i)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // gyro sensitivity times ten, LSB per deg/s
  function automatic logic [10:0] rate_div10(input logic [1:0] r);
    logic [10:0] v;
    unique case (r)
      2'd0: v = 11'd1310;
      2'd1: v = 11'd655;
      2'd2: v = 11'd328;
      2'd3: v = 11'd164;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/imu_complementary_attitude.sv =====
// Complementary-filter attitude estimator, top level.
// Measurement: S_MUL, S_DIV_GO, S_WAIT for the 54-step divider lanes, S_BLD_MUL, S_BLD_SUM,
// S_OUT, then out_tvalid; calibration S_CAL_CHK, S_OUT, or on completion S_DIV_GO, S_WAIT,
// S_OFF_WR, S_OUT. One item at a time: input is taken again once the result is registered;
// S_OUT waits while a held result is not taken. Result waits in an output register while the
// next item may be accepted. Reset (synchronous, rst_n low) clears angles, offsets, sums,
// count, loads register defaults. Depends on imu_ca_pkg, imu_ca_divider, imu_ca_cordic.
`timescale 1ns / 1ps
`default_nettype none
module imu_complementary_attitude
  import imu_ca_pkg::*;
#(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  wire logic [95:0]       in_tdata,
  // action
  input  wire logic              in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // roll_deg, pitch_deg, yaw_deg
  output logic [95:0]            out_tdata,
  // cal_done
  output logic                   out_tuser
);
  localparam int PROP_W = 38;

  state_t state_r, state_nxt;
  ctl_t   ctl;

  logic [1:0]       gyro_range_r;
  logic [TAU_W-1:0] blend_tau_r;
  logic [DT_W-1:0]  sample_period_r;
  logic [CNT_W-1:0] cal_points_r;

  logic                    act_r, cal_done_r, cal_fin_r;
  logic signed [RAW_W-1:0] ax_r, ay_r, az_r;
  logic signed [RAW_W-1:0] g_r [3];
  logic signed [OFS_W-1:0] ofs_r [3];
  logic [SUM_W-1:0]        sum_r [3];
  logic [CNT_W-1:0]        cnt_r;
  logic signed [49:0]      prod_r [3];
  logic signed [ANG_W-1:0] roll_r, pitch_r, yaw_r;
  logic signed [54:0]      mt_roll_r, mt_pitch_r;
  logic signed [49:0]      ma_roll_r, ma_pitch_r;

  logic signed [NUM_W-1:0] div_num [3];
  logic signed [NUM_W-1:0] div_q [3];
  logic [DEN_W-1:0]        div_den;
  logic [2:0]              div_done;
  logic                    cor_done_p, cor_done_r;
  logic signed [ANG_W-1:0] acc_pitch, acc_roll;
  logic [CNT_W-1:0]        target;
  logic                    in_xfer;

  logic out_tvalid_r, out_tuser_r;
  logic [95:0] out_tdata_r;

  assign in_xfer = in_tvalid && in_tready;
  assign target  = (cal_points_r == '0) ? CNT_W'(1) : cal_points_r;

  // round a sum of Q16 products down by 2^16, half away from zero
  function automatic logic signed [39:0] rnd16(input logic signed [55:0] n);
    logic [55:0] m;
    logic [39:0] q;
    m = n[55] ? 56'(-n) : 56'(n);
    q = 40'((m + 56'd32768) >> 16);
    return n[55] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [ANG_W-1:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647)       return 32'sh7fffffff;
    else if (v < -40'sd2147483648) return 32'sh80000000;
    else                           return v[ANG_W-1:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_range_r    <= 2'd1;
      blend_tau_r     <= 16'd64225;
      sample_period_r <= 24'd67109;
      cal_points_r    <= 16'd1000;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GYRO_RANGE:    gyro_range_r    <= cfg_wdata[1:0];
        REG_BLEND_TAU:     blend_tau_r     <= cfg_wdata[TAU_W-1:0];
        REG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata[DT_W-1:0];
        REG_CAL_POINTS:    cal_points_r    <= cfg_wdata[CNT_W-1:0];
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_xfer) state_nxt = (in_tuser == ACT_CALIBRATE) ? S_CAL_CHK : S_MUL;
      S_CAL_CHK: state_nxt = cal_fin_r ? S_DIV_GO : S_OUT;
      S_MUL:     state_nxt = S_DIV_GO;
      S_DIV_GO:  state_nxt = S_WAIT;
      S_WAIT:    if (&div_done && (act_r == ACT_CALIBRATE || (cor_done_r && cor_done_p)))
                   state_nxt = (act_r == ACT_CALIBRATE) ? S_OFF_WR : S_BLD_MUL;
      S_OFF_WR:  state_nxt = S_OUT;
      S_BLD_MUL: state_nxt = S_BLD_SUM;
      S_BLD_SUM: state_nxt = S_OUT;
      S_OUT:     if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ctl.in_ready = (state_r == S_IDLE);
    ctl.div_go   = (state_r == S_DIV_GO);
    ctl.cor_go   = (state_r == S_MUL);
  end

  assign in_tready = ctl.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // divider operands: scaled gyro rate or calibration average
  assign div_den = (act_r == ACT_CALIBRATE)
                 ? ((cnt_r == '0) ? DEN_W'(65536) : DEN_W'(cnt_r))
                 : (DEN_W'(rate_div10(gyro_range_r)) << (32 - ANGLE_FRAC_BITS));

  for (genvar k = 0; k < 3; k++) begin : g_div
    logic signed [NUM_W-1:0] p54;
    assign p54 = NUM_W'(prod_r[k]);
    assign div_num[k] = (act_r == ACT_CALIBRATE)
                      ? (NUM_W'($signed(sum_r[k])) <<< 8)
                      : ((p54 <<< 3) + (p54 <<< 1));
    imu_ca_divider u_div (
      .clk(clk), .rst_n(rst_n), .start(ctl.div_go),
      .num(div_num[k]), .den(div_den), .done(div_done[k]), .quot(div_q[k])
    );
  end

  // accelerometer angle lanes
  imu_ca_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cor_pitch (
    .clk(clk), .rst_n(rst_n), .start(ctl.cor_go),
    .y_in(ay_r), .x_in(az_r), .done(cor_done_p), .angle(acc_pitch)
  );
  imu_ca_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cor_roll (
    .clk(clk), .rst_n(rst_n), .start(ctl.cor_go),
    .y_in(ax_r), .x_in(az_r), .done(cor_done_r), .angle(acc_roll)
  );

  // capture, accumulate and merge
  always_ff @(posedge clk) begin
    logic signed [PROP_W-1:0] pr, pp, yw;
    logic signed [24:0]       gk;
    logic [CNT_W-1:0]         cn;
    if (!rst_n) begin
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
      cnt_r   <= '0;
      for (int k = 0; k < 3; k++) begin
        ofs_r[k] <= '0;
        sum_r[k] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: if (in_xfer) begin
          act_r <= in_tuser;
          ax_r  <= in_tdata[15:0];
          ay_r  <= in_tdata[31:16];
          az_r  <= in_tdata[47:32];
          g_r[0] <= in_tdata[63:48];
          g_r[1] <= in_tdata[79:64];
          g_r[2] <= in_tdata[95:80];
          cal_done_r <= 1'b0;
          if (in_tuser == ACT_CALIBRATE) begin
            cn = cnt_r + CNT_W'(1);
            cnt_r <= cn;
            cal_fin_r <= (cn >= target) || (cn == '0);
            sum_r[0] <= sum_r[0] + SUM_W'($signed(in_tdata[63:48]));
            sum_r[1] <= sum_r[1] + SUM_W'($signed(in_tdata[79:64]));
            sum_r[2] <= sum_r[2] + SUM_W'($signed(in_tdata[95:80]));
          end
        end
        S_MUL: begin
          for (int k = 0; k < 3; k++) begin
            gk = (25'(g_r[k]) <<< 8) - 25'(ofs_r[k]);
            prod_r[k] <= gk * $signed({1'b0, sample_period_r});
          end
        end
        S_OFF_WR: begin
          for (int k = 0; k < 3; k++) begin
            ofs_r[k] <= div_q[k][OFS_W-1:0];
            sum_r[k] <= '0;
          end
          cnt_r      <= '0;
          cal_done_r <= 1'b1;
        end
        S_BLD_MUL: begin
          pr = PROP_W'(roll_r)  - PROP_W'($signed(div_q[1][DELTA_W-1:0]));
          pp = PROP_W'(pitch_r) + PROP_W'($signed(div_q[0][DELTA_W-1:0]));
          mt_roll_r  <= pr * $signed({1'b0, blend_tau_r});
          mt_pitch_r <= pp * $signed({1'b0, blend_tau_r});
          ma_roll_r  <= acc_roll  * $signed({1'b0, 17'(17'd65536 - 17'(blend_tau_r))});
          ma_pitch_r <= acc_pitch * $signed({1'b0, 17'(17'd65536 - 17'(blend_tau_r))});
          yw = PROP_W'(yaw_r) + PROP_W'($signed(div_q[2][DELTA_W-1:0]));
          yaw_r <= sat32(40'(yw));
        end
        S_BLD_SUM: begin
          roll_r  <= sat32(rnd16(56'(mt_roll_r)  + 56'(ma_roll_r)));
          pitch_r <= sat32(rnd16(56'(mt_pitch_r) + 56'(ma_pitch_r)));
        end
        default: ;
      endcase
    end
  end

  // output register, parts the result from the next input
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {yaw_r, pitch_r, roll_r};
        out_tuser_r  <= cal_done_r;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
endmodule
`default_nettype wire

// ===== hw/rtl/imu_ca_divider.sv =====
// Restoring divider lane, one quotient bit per cycle, rounds half away from zero.
// Depends on imu_ca_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module imu_ca_divider
  import imu_ca_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic        [DEN_W-1:0] den,
  output logic                         done,
  output logic signed [NUM_W-1:0]      quot
);
  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r, done_r, neg_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   rsh;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign rsh = {rem_r, q_r[NUM_W-1]};

  // iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      neg_r  <= num[NUM_W-1];
      q_r    <= mag + NUM_W'(den >> 1);
      rem_r  <= '0;
      den_r  <= den;
      cnt_r  <= CW'(NUM_W);
    end else if (busy_r) begin
      if (rsh >= {1'b0, den_r}) begin
        rem_r <= DEN_W'(rsh - {1'b0, den_r});
        q_r   <= {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rsh[DEN_W-1:0];
        q_r   <= {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule
`default_nettype wire

// ===== hw/rtl/imu_ca_cordic.sv =====
// CORDIC vectoring lane: atan2(y, x) in degrees, one micro-rotation per cycle.
// Depends on imu_ca_pkg for the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
module imu_ca_cordic
  import imu_ca_pkg::*;
#(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [RAW_W-1:0] y_in,
  input  wire logic signed [RAW_W-1:0] x_in,
  output logic                         done,
  output logic signed [ANG_W-1:0]      angle
);
  localparam int N  = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam int SH = 24 - ANGLE_FRAC_BITS;
  localparam logic signed [33:0] HALF_TURN = 34'sd3019898880;

  logic                busy_r, done_r, axis_r;
  logic signed [39:0]  x_r, y_r, xs, ys, xe, ye;
  logic signed [33:0]  z_r, mz, qz;
  logic [STEP_W-1:0]   i_r;
  logic signed [ANG_W-1:0] axis_ang_r;

  assign xe = 40'(x_in);
  assign ye = 40'(y_in);
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;

  // run the rotations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      done_r <= 1'b0;
      i_r    <= '0;
      if (y_in == '0) begin
        axis_r     <= 1'b1;
        axis_ang_r <= x_in[RAW_W-1] ? (ANG_W'(180) <<< ANGLE_FRAC_BITS) : '0;
        done_r     <= 1'b1;
      end else begin
        axis_r <= 1'b0;
        busy_r <= 1'b1;
        if (x_in[RAW_W-1]) begin
          x_r <= (-xe) <<< 20;
          y_r <= (-ye) <<< 20;
          z_r <= y_in[RAW_W-1] ? -HALF_TURN : HALF_TURN;
        end else begin
          x_r <= xe <<< 20;
          y_r <= ye <<< 20;
          z_r <= '0;
        end
      end
    end else if (busy_r) begin
      if (!y_r[39]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_lut(i_r);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_lut(i_r);
      end
      i_r <= i_r + STEP_W'(1);
      if (i_r == STEP_W'(N - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // round to the output fraction, half away from zero
  assign mz = z_r[33] ? -z_r : z_r;
  assign qz = (mz + (34'sd1 <<< (SH - 1))) >>> SH;

  assign done  = done_r;
  assign angle = axis_r ? axis_ang_r : (z_r[33] ? ANG_W'(-qz) : ANG_W'(qz));
endmodule
`default_nettype wire

// ===== hw/rtl/imu_ca_checker.sv =====
// Port-level checker for the attitude block, bound to the top level.
// Depends on the top level's port names only.
`timescale 1ns / 1ps
`default_nettype none
module imu_ca_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [95:0] out_tdata
);
  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one item at a time: busy after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // reset leaves no result and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");
endmodule

bind imu_complementary_attitude imu_ca_checker u_chk (.*);
`default_nettype wire
